/* src/morse_tone_symbol_recogniser_assert.svh */
// Assertion macros for the Morse tone symbol recogniser.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef MORSE_TONE_SYMBOL_RECOGNISER_ASSERT_SVH
`define MORSE_TONE_SYMBOL_RECOGNISER_ASSERT_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset
`define MSR_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on every clock edge, reset included
`define MSR_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MSR_ASSERT(name, clk, rst_n, prop, msg)
`define MSR_ASSERT_ALWAYS(name, clk, prop, msg)
`endif
`endif

/* src/msr_pkg.sv */
// Shared constants, codes and types of the Morse tone symbol recogniser.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package msr_pkg;

  // Sizing
  localparam int MAX_UNIT        = 32;
  localparam int PEAKS_PER_FRAME = 3;
  localparam int PEAK_FIELDS     = 3;
  localparam int WIN_DEPTH       = 2 * MAX_UNIT;
  localparam int UNIT_W          = $clog2(MAX_UNIT + 1);
  localparam int IDX_W           = (MAX_UNIT > 1) ? $clog2(MAX_UNIT) : 1;
  localparam int FILL_W          = $clog2(WIN_DEPTH + 1);

  // Field widths
  localparam int FREQ_W  = 14;
  localparam int TOL_W   = 10;
  localparam int TU_W    = 6;
  localparam int CNT_W   = 6;
  localparam int PCNT_W  = 2;
  localparam int SYM_W   = 3;
  localparam int UNITS_W = 8;
  localparam int DIFF_W  = FREQ_W + 2;
  localparam int CMP_W   = (UNIT_W > CNT_W) ? UNIT_W : CNT_W;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;

  // Detection constants
  localparam int COMP_HZ    = 50;
  localparam int LETTER_MIN = 2;
  localparam int LETTER_MAX = 4;
  localparam int WORD_MAX   = 8;
  localparam int EOT_UNITS  = 9;
  localparam int DOT_MAX    = 2;
  localparam int UNITS_MAX  = 255;

  // Register reset values
  localparam logic [FREQ_W-1:0] RST_TARGET    = FREQ_W'(1000);
  localparam logic [TOL_W-1:0]  RST_TOLERANCE = TOL_W'(50);
  localparam logic [TU_W-1:0]   RST_UNIT      = TU_W'(4);
  localparam logic [CNT_W-1:0]  RST_START     = CNT_W'(3);
  localparam logic [CNT_W-1:0]  RST_END       = CNT_W'(2);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE      = 3'd0,
    REG_TARGET_FREQ = 3'd1,
    REG_TOLERANCE   = 3'd2,
    REG_TIME_UNIT   = 3'd3,
    REG_START_COUNT = 3'd4,
    REG_END_COUNT   = 3'd5
  } cfg_reg_t;

  typedef enum logic [SYM_W-1:0] {
    SYM_DOT    = 3'd0,
    SYM_DASH   = 3'd1,
    SYM_LETTER = 3'd2,
    SYM_WORD   = 3'd3,
    SYM_EOT    = 3'd4
  } symbol_t;

  typedef enum logic {
    ST_GAP  = 1'b0,
    ST_TONE = 1'b1
  } tone_state_t;

  typedef logic [FREQ_W-1:0] freq_t;

  // Live configuration plus the window-empty pulse of a disable write
  typedef struct packed {
    logic              enable;
    logic [FREQ_W-1:0] target_freq;
    logic [TOL_W-1:0]  tolerance;
    logic [TU_W-1:0]   time_unit;
    logic [CNT_W-1:0]  start_count;
    logic [CNT_W-1:0]  end_count;
    logic              win_clear;
  } cfg_t;

endpackage

/* src/msr_cfg_regs.sv */
// Configuration register file of the Morse tone symbol recogniser.
// Depends on msr_pkg for register codes, widths and reset values.
`timescale 1ns / 1ps

module msr_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [msr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [msr_pkg::CFG_DATA_W-1:0]   cfg_data,
  output msr_pkg::cfg_t                    cfg
);
  import msr_pkg::*;

  logic              enable_r, enable_nxt;
  logic [FREQ_W-1:0] target_r, target_nxt;
  logic [TOL_W-1:0]  tol_r, tol_nxt;
  logic [TU_W-1:0]   unit_r, unit_nxt;
  logic [CNT_W-1:0]  start_r, start_nxt;
  logic [CNT_W-1:0]  end_r, end_nxt;
  logic              wr;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid && cfg_ready;

  // Decode the write transfer
  always_comb begin
    enable_nxt = enable_r;
    target_nxt = target_r;
    tol_nxt    = tol_r;
    unit_nxt   = unit_r;
    start_nxt  = start_r;
    end_nxt    = end_r;
    if (wr) begin
      case (cfg_reg_t'(cfg_index))
        REG_ENABLE:      enable_nxt = cfg_data[0];
        REG_TARGET_FREQ: target_nxt = cfg_data[FREQ_W-1:0];
        REG_TOLERANCE:   tol_nxt    = cfg_data[TOL_W-1:0];
        REG_TIME_UNIT:   unit_nxt   = cfg_data[TU_W-1:0];
        REG_START_COUNT: start_nxt  = cfg_data[CNT_W-1:0];
        REG_END_COUNT:   end_nxt    = cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      target_r <= RST_TARGET;
      tol_r    <= RST_TOLERANCE;
      unit_r   <= RST_UNIT;
      start_r  <= RST_START;
      end_r    <= RST_END;
    end else begin
      enable_r <= enable_nxt;
      target_r <= target_nxt;
      tol_r    <= tol_nxt;
      unit_r   <= unit_nxt;
      start_r  <= start_nxt;
      end_r    <= end_nxt;
    end
  end

  // Present the register set; a disable write also empties the window
  always_comb begin
    cfg.enable      = enable_r;
    cfg.target_freq = target_r;
    cfg.tolerance   = tol_r;
    cfg.time_unit   = unit_r;
    cfg.start_count = start_r;
    cfg.end_count   = end_r;
    cfg.win_clear   = wr && (cfg_reg_t'(cfg_index) == REG_ENABLE) && !cfg_data[0];
  end

endmodule

/* src/msr_tone_detect.sv */
// Tone bit detector: matches the frame's peaks against the compensated target.
// Depends on msr_pkg for widths and the configuration struct.
`timescale 1ns / 1ps

module msr_tone_detect (
  input  msr_pkg::cfg_t                               cfg,
  input  logic [msr_pkg::PCNT_W-1:0]                  peak_count,
  input  msr_pkg::freq_t [msr_pkg::PEAK_FIELDS-1:0]   peak_freq,
  output logic                                        tone_bit
);
  import msr_pkg::*;

  logic signed [DIFF_W-1:0] target;
  logic signed [DIFF_W-1:0] diff [PEAK_FIELDS];
  logic        [DIFF_W-1:0] mag  [PEAK_FIELDS];
  logic [PEAK_FIELDS-1:0]   hit;

  // Target after the 50 Hz compensation; may go negative
  assign target = $signed({2'b00, cfg.target_freq}) - $signed(DIFF_W'(COMP_HZ));

  // Compare each valid peak's distance against the tolerance
  always_comb begin
    for (int i = 0; i < PEAK_FIELDS; i++) begin
      diff[i] = $signed({2'b00, peak_freq[i]}) - target;
      mag[i]  = diff[i][DIFF_W-1] ? DIFF_W'(-diff[i]) : DIFF_W'(diff[i]);
      hit[i]  = (i < PEAKS_PER_FRAME) && (PCNT_W'(i) < peak_count) &&
                (mag[i] < DIFF_W'(cfg.tolerance));
    end
  end

  assign tone_bit = |hit;

endmodule

/* src/msr_symbol_fsm.sv */
// Tone window, unit counters, symbol decisions and the result register.
// Depends on msr_pkg and on the assertion macro header.
`timescale 1ns / 1ps

module msr_symbol_fsm (
  input  logic                          clk,
  input  logic                          rst_n,
  input  msr_pkg::cfg_t                 cfg,
  input  logic                          item_valid,
  input  logic                          tone_bit,
  output logic                          item_take,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic [msr_pkg::SYM_W-1:0]     out_symbol
);
  import msr_pkg::*;
  `include "morse_tone_symbol_recogniser_assert.svh"

  tone_state_t          state_r, state_nxt;
  logic [MAX_UNIT-1:0]  window_r, window_nxt;
  logic [FILL_W-1:0]    fill_r, fill_nxt;
  logic [UNITS_W-1:0]   gap_r, gap_nxt;
  logic [UNITS_W-1:0]   tone_r, tone_nxt;
  logic                 msg_open_r, msg_open_nxt;
  logic                 out_valid_r, out_valid_nxt;
  symbol_t              out_sym_r, out_sym_nxt;

  logic [UNIT_W-1:0]    unit_c;
  logic [MAX_UNIT-1:0]  win_new;
  logic [MAX_UNIT-1:0]  unit_mask;
  logic [UNIT_W-1:0]    pop;
  logic [UNIT_W-1:0]    oldest_idx;
  logic                 oldest;
  logic [FILL_W-1:0]    fill_new;
  logic                 work;
  logic                 unit_ready;
  logic                 full;
  logic                 fire_start;
  logic                 fire_end;
  logic [UNITS_W-1:0]   gap_sum;
  logic [UNITS_W-1:0]   tone_sum;

  function automatic logic [UNITS_W-1:0] sat_inc(input logic [UNITS_W-1:0] a,
                                                 input logic b);
    logic [UNITS_W:0] s;
    s = {1'b0, a} + (UNITS_W+1)'(b);
    return (s > (UNITS_W+1)'(UNITS_MAX)) ? UNITS_W'(UNITS_MAX) : s[UNITS_W-1:0];
  endfunction

  // Take an item whenever the result slot is free or drains this cycle
  assign item_take = item_valid && (!out_valid_r || !out_stall);
  assign work      = item_take && cfg.enable;

  // Clamp the unit length into its legal range
  always_comb begin
    if (cfg.time_unit == '0) begin
      unit_c = UNIT_W'(1);
    end else if (32'(cfg.time_unit) > MAX_UNIT) begin
      unit_c = UNIT_W'(MAX_UNIT);
    end else begin
      unit_c = UNIT_W'(cfg.time_unit);
    end
  end

  // Newest bit enters at position zero; the last unit is the low unit_c bits
  assign win_new  = {window_r[MAX_UNIT-2:0], tone_bit};
  assign fill_new = fill_r + FILL_W'(1);

  always_comb begin
    for (int i = 0; i < MAX_UNIT; i++) begin
      unit_mask[i] = (UNIT_W'(i) < unit_c);
    end
  end

  assign pop        = UNIT_W'($countones(win_new & unit_mask));
  assign oldest_idx = unit_c - UNIT_W'(1);
  assign oldest     = win_new[oldest_idx[IDX_W-1:0]];
  assign unit_ready = fill_new >= FILL_W'(unit_c);
  assign full       = fill_new >= FILL_W'({unit_c, 1'b0});

  assign fire_start = work && unit_ready && (state_r == ST_GAP) && oldest &&
                      (CMP_W'(pop) >= CMP_W'(cfg.start_count));
  assign fire_end   = work && unit_ready && (state_r == ST_TONE) && !oldest &&
                      (CMP_W'(pop) < CMP_W'(cfg.end_count));

  assign gap_sum  = sat_inc(gap_r, full);
  assign tone_sum = sat_inc(tone_r, full);

  // Next state, counters and result
  always_comb begin
    state_nxt     = state_r;
    window_nxt    = window_r;
    fill_nxt      = fill_r;
    gap_nxt       = gap_r;
    tone_nxt      = tone_r;
    msg_open_nxt  = msg_open_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_sym_nxt   = out_sym_r;

    if (item_take) begin
      out_valid_nxt = 1'b0;
    end

    if (work) begin
      window_nxt = win_new;
      fill_nxt   = fill_new;
      if (fire_start) begin
        // Tone start closes the gap
        if (msg_open_r && (gap_sum inside {[LETTER_MIN:LETTER_MAX]})) begin
          out_valid_nxt = 1'b1;
          out_sym_nxt   = SYM_LETTER;
        end else if (msg_open_r && (gap_sum inside {[LETTER_MAX+1:WORD_MAX]})) begin
          out_valid_nxt = 1'b1;
          out_sym_nxt   = SYM_WORD;
        end
        fill_nxt  = '0;
        gap_nxt   = '0;
        tone_nxt  = UNITS_W'(1);
        state_nxt = ST_TONE;
      end else if (fire_end) begin
        // Tone end closes the mark
        out_valid_nxt = 1'b1;
        out_sym_nxt   = (tone_sum > UNITS_W'(DOT_MAX)) ? SYM_DASH : SYM_DOT;
        msg_open_nxt  = 1'b1;
        fill_nxt      = '0;
        gap_nxt       = UNITS_W'(1);
        tone_nxt      = '0;
        state_nxt     = ST_GAP;
      end else if (unit_ready && full) begin
        // One more whole unit; keep only the newest unit of bits
        if (msg_open_r && (gap_r == UNITS_W'(EOT_UNITS))) begin
          out_valid_nxt = 1'b1;
          out_sym_nxt   = SYM_EOT;
          msg_open_nxt  = 1'b0;
        end
        if (state_r == ST_TONE) begin
          tone_nxt = sat_inc(tone_r, 1'b1);
        end else begin
          gap_nxt = sat_inc(gap_r, 1'b1);
        end
        fill_nxt = FILL_W'(unit_c);
      end
    end

    if (cfg.win_clear) begin
      fill_nxt = '0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_GAP;
      fill_r      <= '0;
      gap_r       <= '0;
      tone_r      <= '0;
      msg_open_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      gap_r       <= gap_nxt;
      tone_r      <= tone_nxt;
      msg_open_r  <= msg_open_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Window bits and result payload
  always_ff @(posedge clk) begin
    window_r  <= window_nxt;
    out_sym_r <= out_sym_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_symbol = out_sym_r;

  `MSR_ASSERT(a_fill_bound, clk, rst_n, fill_r < FILL_W'(WIN_DEPTH), "window fill out of range")
  `MSR_ASSERT(a_out_source, clk, rst_n, (out_valid_r && !$past(out_valid_r)) |-> $past(item_take), "result without a taken item")
  `MSR_ASSERT(a_end_opens, clk, rst_n, fire_end |=> (msg_open_r && (state_r == ST_GAP)), "tone end did not open the message")
  `MSR_ASSERT(a_start_state, clk, rst_n, fire_start |=> ((state_r == ST_TONE) && (gap_r == '0)), "tone start state not taken")
  `MSR_ASSERT_ALWAYS(a_reset_clear, clk, !rst_n |=> ((fill_r == '0) && !out_valid_r && !msg_open_r), "reset left state behind")

endmodule

/* src/morse_tone_symbol_recogniser.sv */
// Top level of the Morse tone symbol recogniser: input register and wiring.
// Depends on msr_pkg, msr_cfg_regs, msr_tone_detect and msr_symbol_fsm.
//
//   Channel  Signals                                         Direction
//   in       in_valid / in_stall, in_peak_count, in_peak_freq_0..2   frame in
//   out      out_valid / out_stall, out_symbol               symbol out
//   cfg      cfg_valid / cfg_ready, cfg_index, cfg_data      register write
//
// One frame per cycle sustained while the result is not stalled; a symbol leaves through
// the input register, then the result register behind the window logic.
// Reset (rst_n low, synchronous) empties the window, clears counters and the result.
// A stalled result holds the frame in the input register; in_stall then rises.
// cfg_ready is always high; register writes take effect on the next cycle.
`timescale 1ns / 1ps

module morse_tone_symbol_recogniser (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [msr_pkg::PCNT_W-1:0]        in_peak_count,
  input  logic [msr_pkg::FREQ_W-1:0]        in_peak_freq_0,
  input  logic [msr_pkg::FREQ_W-1:0]        in_peak_freq_1,
  input  logic [msr_pkg::FREQ_W-1:0]        in_peak_freq_2,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [msr_pkg::SYM_W-1:0]         out_symbol,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [msr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [msr_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import msr_pkg::*;

  cfg_t                     cfg;
  logic                     s1_valid_r, s1_valid_nxt;
  logic [PCNT_W-1:0]        s1_count_r;
  freq_t [PEAK_FIELDS-1:0]  s1_freq_r;
  logic                     in_xfer;
  logic                     item_take;
  logic                     tone_bit;

  // Input register: refill when empty or when its frame moves on
  assign in_stall = s1_valid_r && !item_take;
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (item_take) begin
      s1_valid_nxt = 1'b0;
    end
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_count_r   <= in_peak_count;
      s1_freq_r[0] <= in_peak_freq_0;
      s1_freq_r[1] <= in_peak_freq_1;
      s1_freq_r[2] <= in_peak_freq_2;
    end
  end

  msr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  msr_tone_detect u_detect (
    .cfg        (cfg),
    .peak_count (s1_count_r),
    .peak_freq  (s1_freq_r),
    .tone_bit   (tone_bit)
  );

  msr_symbol_fsm u_fsm (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (s1_valid_r),
    .tone_bit   (tone_bit),
    .item_take  (item_take),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_symbol (out_symbol)
  );

endmodule

/* sim/morse_tone_symbol_recogniser_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for morse_tone_symbol_recogniser: frames, register writes
// and result back-pressure, with symbols predicted by a local model or pinned by the table.
// Depends on msr_pkg and the morse_tone_symbol_recogniser top level.

module morse_tone_symbol_recogniser_tb;
  import msr_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE       = 6;
  localparam int PHASE_FRAMES = 16;
  localparam int N_PHASES     = 10;
  localparam int SAT_RUN      = 256;
  localparam int HOLD_CYCLES  = 300;

  typedef struct packed {
    logic [PCNT_W-1:0] count;
    freq_t             f0;
    freq_t             f1;
    freq_t             f2;
  } frame_t;

  typedef enum logic [1:0] {
    ROW_REG,
    ROW_FRAME,
    ROW_FRAME_QUIET,
    ROW_FRAME_SYM
  } row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    cfg_reg_t              regsel;
    logic [CFG_DATA_W-1:0] data;
    frame_t                frame;
    symbol_t               sym;
  } row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [PCNT_W-1:0]     in_peak_count;
  freq_t                 in_peak_freq_0;
  freq_t                 in_peak_freq_1;
  freq_t                 in_peak_freq_2;
  logic                  out_valid;
  logic                  out_stall;
  logic [SYM_W-1:0]      out_symbol;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Shadow registers
  logic             en_r;
  freq_t            tgt_r;
  logic [TOL_W-1:0] tol_r;
  logic [TU_W-1:0]  unit_r;
  logic [CNT_W-1:0] start_r;
  logic [CNT_W-1:0] stop_r;

  // Shadow decoder state
  logic               win [0:WIN_DEPTH-1];
  logic [FILL_W-1:0]  win_fill;
  logic [UNITS_W-1:0] gap_len;
  logic [UNITS_W-1:0] mark_len;
  tone_state_t        tone_st;
  logic               msg_live;

  symbol_t expected_symbols[$];
  row_t    dir_rows[$];
  int      err_cnt;
  int      cycles;
  int      frames_sent;
  int      send_idle_pct;
  int      stall_pct;
  int      hold_left;

  morse_tone_symbol_recogniser dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // End the run on a hang
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Drive result back-pressure: a long hold when requested, else random stalls
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      out_stall = ($urandom_range(99) < stall_pct);
    end
  end

  // Compare each symbol transfer with the oldest expectation
  always @(posedge clk) begin
    symbol_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_symbols.size() == 0) begin
        $error("symbol: no expectation waiting, actual %0d", out_symbol);
        err_cnt++;
      end else begin
        want = expected_symbols.pop_front();
        if (out_symbol !== want) begin
          $error("symbol: expected %0d, actual %0d", want, out_symbol);
          err_cnt++;
        end
      end
    end
  end

  function automatic logic [UNITS_W-1:0] bump(logic [UNITS_W-1:0] v, bit inc);
    return (inc && v != UNITS_W'(UNITS_MAX)) ? v + 1'b1 : v;
  endfunction

  function automatic int eff_unit();
    int u;
    u = int'(unit_r);
    if (u < 1) u = 1;
    if (u > MAX_UNIT) u = MAX_UNIT;
    return u;
  endfunction

  // Advance the shadow decoder by one frame; report the symbol it emits, if any
  function automatic void predict_frame(frame_t f, output bit has, output symbol_t s);
    int      unit, target, diff, pop, lim, base, i;
    freq_t   pk [0:2];
    logic    hit, oldest, full;
    bit      want;
    symbol_t cand;
    has  = 0;
    s    = SYM_DOT;
    hit  = 0;
    want = 0;
    cand = SYM_DOT;
    if (!en_r) return;
    unit = eff_unit();
    lim = int'(f.count);
    if (lim > PEAKS_PER_FRAME) lim = PEAKS_PER_FRAME;
    if (lim > PEAK_FIELDS) lim = PEAK_FIELDS;
    pk[0] = f.f0;
    pk[1] = f.f1;
    pk[2] = f.f2;
    // Signed distance to the compensated target
    target = int'(tgt_r) - COMP_HZ;
    for (i = 0; i < lim; i++) begin
      diff = int'(pk[i]) - target;
      if (diff < 0) diff = -diff;
      if (diff < int'(tol_r)) hit = 1'b1;
    end
    if (win_fill >= WIN_DEPTH) win_fill = FILL_W'(WIN_DEPTH - 1);
    win[win_fill] = hit;
    win_fill++;
    if (int'(win_fill) < unit) return;
    base = int'(win_fill) - unit;
    pop = 0;
    for (i = base; i < int'(win_fill); i++) pop += win[i];
    oldest = win[base];
    full = (int'(win_fill) >= 2 * unit);
    if (tone_st == ST_GAP && pop >= int'(start_r) && oldest) begin
      // Tone start closes the gap
      gap_len = bump(gap_len, full);
      if (gap_len >= LETTER_MIN && gap_len <= LETTER_MAX) begin
        want = 1;
        cand = SYM_LETTER;
      end else if (gap_len > LETTER_MAX && gap_len <= WORD_MAX) begin
        want = 1;
        cand = SYM_WORD;
      end
      win_fill = '0;
      gap_len  = '0;
      mark_len = UNITS_W'(1);
      tone_st  = ST_TONE;
    end else if (tone_st == ST_TONE && pop < int'(stop_r) && !oldest) begin
      // Tone end closes the mark
      mark_len = bump(mark_len, full);
      want = 1;
      cand = (mark_len > DOT_MAX) ? SYM_DASH : SYM_DOT;
      win_fill = '0;
      tone_st  = ST_GAP;
      gap_len  = UNITS_W'(1);
      mark_len = '0;
    end else if (full) begin
      // Count one unit and keep the newest unit of bits
      if (gap_len == EOT_UNITS) begin
        want = 1;
        cand = SYM_EOT;
      end
      if (tone_st == ST_TONE) mark_len = bump(mark_len, 1'b1);
      else gap_len = bump(gap_len, 1'b1);
      for (i = 0; i < unit; i++) win[i] = win[base + i];
      win_fill = FILL_W'(unit);
    end
    // Drop spaces and end marks before the first mark of a message
    if (want && (msg_live || cand == SYM_DOT || cand == SYM_DASH)) begin
      has = 1;
      s = cand;
      msg_live = (cand != SYM_EOT);
    end
  endfunction

  function automatic void shadow_write(cfg_reg_t r, logic [CFG_DATA_W-1:0] d);
    case (r)
      REG_ENABLE: begin
        en_r = d[0];
        if (!d[0]) win_fill = '0;
      end
      REG_TARGET_FREQ: tgt_r   = d[FREQ_W-1:0];
      REG_TOLERANCE:   tol_r   = d[TOL_W-1:0];
      REG_TIME_UNIT:   unit_r  = d[TU_W-1:0];
      REG_START_COUNT: start_r = d[CNT_W-1:0];
      REG_END_COUNT:   stop_r  = d[CNT_W-1:0];
      default: ;
    endcase
  endfunction

  // A frequency that lies inside the current tolerance band
  function automatic freq_t near_target();
    int tl, v;
    tl = int'(tol_r);
    v = int'(tgt_r) - COMP_HZ;
    if (tl > 1) v = v + int'($urandom_range(2 * tl - 2)) - (tl - 1);
    if (v < 0) v = 0;
    if (v > 16383) v = 16383;
    return FREQ_W'(v);
  endfunction

  function automatic frame_t tone_frame();
    frame_t f;
    int     k;
    f.count = PCNT_W'($urandom_range(3, 1));
    f.f0 = FREQ_W'($urandom);
    f.f1 = FREQ_W'($urandom);
    f.f2 = FREQ_W'($urandom);
    k = $urandom_range(int'(f.count) - 1);
    case (k)
      0:       f.f0 = near_target();
      1:       f.f1 = near_target();
      default: f.f2 = near_target();
    endcase
    return f;
  endfunction

  function automatic frame_t quiet_frame();
    frame_t f;
    f.count = PCNT_W'($urandom);
    f.f0 = FREQ_W'($urandom);
    f.f1 = FREQ_W'($urandom);
    f.f2 = FREQ_W'($urandom);
    // Hide a matching peak behind a zero peak count
    if ($urandom_range(3) == 0) begin
      f.count = '0;
      f.f0 = near_target();
    end
    return f;
  endfunction

  function automatic row_t reg_row(cfg_reg_t r, int d);
    row_t w;
    w = '0;
    w.kind   = ROW_REG;
    w.regsel = r;
    w.data   = CFG_DATA_W'(d);
    return w;
  endfunction

  function automatic row_t frame_row(row_kind_t k, int c, int a, int b, int e, symbol_t s);
    row_t w;
    w = '0;
    w.kind        = k;
    w.frame.count = PCNT_W'(c);
    w.frame.f0    = FREQ_W'(a);
    w.frame.f1    = FREQ_W'(b);
    w.frame.f2    = FREQ_W'(e);
    w.sym         = s;
    return w;
  endfunction

  task automatic write_reg(cfg_reg_t r, int d);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = r;
    cfg_data  = CFG_DATA_W'(d);
    do @(posedge clk); while (!cfg_ready);
    shadow_write(r, cfg_data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Offer one frame after random idle cycles; a pinned row overrides the prediction
  task automatic send_frame(frame_t f, bit pinned, bit pin_has, symbol_t pin_sym);
    bit      has;
    symbol_t s;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid       = 1'b1;
    in_peak_count  = f.count;
    in_peak_freq_0 = f.f0;
    in_peak_freq_1 = f.f1;
    in_peak_freq_2 = f.f2;
    do @(posedge clk); while (in_stall);
    predict_frame(f, has, s);
    if (pinned) begin
      has = pin_has;
      s   = pin_sym;
    end
    if (has) expected_symbols.push_back(s);
    frames_sent++;
  endtask

  task automatic send_run(bit tone, int len, int flip_pct);
    frame_t f;
    int     i;
    for (i = 0; i < len; i++) begin
      if (tone ^ ($urandom_range(99) < flip_pct)) f = tone_frame();
      else f = quiet_frame();
      send_frame(f, 1'b0, 1'b0, SYM_DOT);
    end
  endtask

  // Stop offering, wait for every expected symbol, then let the pipeline empty
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_symbols.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0:       begin send_idle_pct = 0;  stall_pct = 0;  end
      1:       begin send_idle_pct = 57; stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  stall_pct = 57; end
      default: begin send_idle_pct = 14; stall_pct = 14; end
    endcase
  endtask

  task automatic run_phase(int p);
    int ue, r, n, first, st;
    bit paused;
    paused = 0;
    drain();
    set_idling(p % 4);
    // Even phases empty the window; odd ones keep it across a unit change
    if (p % 2 == 0) write_reg(REG_ENABLE, 0);
    write_reg(REG_ENABLE, 1);
    case (p % 5)
      0:       write_reg(REG_TARGET_FREQ, 1000);
      2:       write_reg(REG_TARGET_FREQ, 50);
      3:       write_reg(REG_TARGET_FREQ, 16383);
      default: write_reg(REG_TARGET_FREQ, $urandom_range(16383, 50));
    endcase
    case (p % 3)
      0:       write_reg(REG_TOLERANCE, 50);
      1:       write_reg(REG_TOLERANCE, $urandom_range(1023, 1));
      default: write_reg(REG_TOLERANCE, (p < 5) ? 1 : 1023);
    endcase
    case (p)
      0, 9:    write_reg(REG_TIME_UNIT, 1);
      1:       write_reg(REG_TIME_UNIT, 2);
      2:       write_reg(REG_TIME_UNIT, 4);
      3:       write_reg(REG_TIME_UNIT, 3);
      4:       write_reg(REG_TIME_UNIT, 8);
      5:       write_reg(REG_TIME_UNIT, $urandom_range(12, 5));
      6:       write_reg(REG_TIME_UNIT, 16);
      7:       write_reg(REG_TIME_UNIT, 0);
      default: write_reg(REG_TIME_UNIT, 63);
    endcase
    ue = eff_unit();
    st = (p == 3) ? 0 : ((p == 5) ? ue : $urandom_range(ue, 1));
    write_reg(REG_START_COUNT, st);
    write_reg(REG_END_COUNT, (p == 7) ? 63 : $urandom_range(ue, 1));
    // Hold the result side off while frames keep coming
    if (p == 0) hold_left = HOLD_CYCLES;
    first = frames_sent;
    while (frames_sent - first < PHASE_FRAMES) begin
      if (p == 1 && !paused && frames_sent - first >= PHASE_FRAMES / 2) begin
        drain();
        paused = 1;
      end
      r = $urandom_range(99);
      if (r < 70) begin
        // Well-formed mark and gap with a little timing jitter
        n = ue * ($urandom_range(1) ? 3 : 1) + int'($urandom_range(2)) - 1;
        send_run(1'b1, (n < 1) ? 1 : n, 8);
        case ($urandom_range(2))
          0:       n = ue;
          1:       n = 3 * ue;
          default: n = 7 * ue;
        endcase
        n = n + int'($urandom_range(2)) - 1;
        send_run(1'b0, (n < 1) ? 1 : n, 8);
      end else if (r < 80 && ue <= 8) begin
        // Long silence: end of transmission
        send_run(1'b0, ue * $urandom_range(12, 10), 3);
      end else begin
        send_run($urandom_range(1), $urandom_range(4, 1), 50);
      end
    end
  endtask

  initial begin
    int p;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_peak_count  = '0;
    in_peak_freq_0 = '0;
    in_peak_freq_1 = '0;
    in_peak_freq_2 = '0;
    out_stall      = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = REG_ENABLE;
    cfg_data       = '0;
    err_cnt        = 0;
    cycles         = 0;
    frames_sent    = 0;
    send_idle_pct  = 0;
    stall_pct      = 0;
    hold_left      = 0;

    // Shadow reset state
    en_r     = 1'b0;
    tgt_r    = RST_TARGET;
    tol_r    = RST_TOLERANCE;
    unit_r   = RST_UNIT;
    start_r  = RST_START;
    stop_r   = RST_END;
    win_fill = '0;
    gap_len  = '0;
    mark_len = '0;
    tone_st  = ST_GAP;
    msg_live = 1'b0;

    // Directed table: disabled after reset, unit-of-one marks, band edges,
    // zero peak count, low target, out-of-range units and count extremes
    dir_rows.push_back(frame_row(ROW_FRAME_QUIET, 3, 950, 950, 950, SYM_DOT));
    dir_rows.push_back(reg_row(REG_ENABLE, 1));
    dir_rows.push_back(reg_row(REG_TIME_UNIT, 1));
    dir_rows.push_back(reg_row(REG_START_COUNT, 1));
    dir_rows.push_back(reg_row(REG_END_COUNT, 1));
    dir_rows.push_back(frame_row(ROW_FRAME, 0, 950, 950, 950, SYM_DOT));
    dir_rows.push_back(frame_row(ROW_FRAME, 1, 950, 0, 0, SYM_DOT));
    dir_rows.push_back(frame_row(ROW_FRAME_SYM, 0, 0, 0, 0, SYM_DOT));
    dir_rows.push_back(frame_row(ROW_FRAME, 3, 0, 16383, 0, SYM_DOT));
    dir_rows.push_back(frame_row(ROW_FRAME, 3, 16383, 16383, 16383, SYM_DOT));
    dir_rows.push_back(frame_row(ROW_FRAME, 2, 0, 999, 0, SYM_DOT));
    dir_rows.push_back(frame_row(ROW_FRAME, 2, 16383, 901, 0, SYM_DOT));
    dir_rows.push_back(frame_row(ROW_FRAME, 3, 0, 0, 950, SYM_DOT));
    dir_rows.push_back(frame_row(ROW_FRAME, 3, 900, 1000, 951, SYM_DOT));
    dir_rows.push_back(frame_row(ROW_FRAME_SYM, 1, 1000, 0, 0, SYM_DASH));
    dir_rows.push_back(reg_row(REG_TARGET_FREQ, 0));
    dir_rows.push_back(reg_row(REG_TOLERANCE, 1023));
    dir_rows.push_back(frame_row(ROW_FRAME, 1, 972, 0, 0, SYM_DOT));
    dir_rows.push_back(frame_row(ROW_FRAME, 1, 973, 0, 0, SYM_DOT));
    dir_rows.push_back(reg_row(REG_TARGET_FREQ, 16383));
    dir_rows.push_back(reg_row(REG_TOLERANCE, 1));
    dir_rows.push_back(frame_row(ROW_FRAME, 1, 16333, 0, 0, SYM_DOT));
    dir_rows.push_back(frame_row(ROW_FRAME, 1, 16334, 0, 0, SYM_DOT));
    dir_rows.push_back(reg_row(REG_ENABLE, 0));
    dir_rows.push_back(frame_row(ROW_FRAME_QUIET, 3, 16333, 16333, 16333, SYM_DOT));
    dir_rows.push_back(reg_row(REG_ENABLE, 1));
    dir_rows.push_back(reg_row(REG_TIME_UNIT, 0));
    dir_rows.push_back(frame_row(ROW_FRAME, 1, 16333, 0, 0, SYM_DOT));
    dir_rows.push_back(frame_row(ROW_FRAME, 0, 16333, 0, 0, SYM_DOT));
    dir_rows.push_back(reg_row(REG_TIME_UNIT, 63));
    dir_rows.push_back(reg_row(REG_START_COUNT, 0));
    dir_rows.push_back(reg_row(REG_END_COUNT, 63));
    dir_rows.push_back(frame_row(ROW_FRAME, 2, 0, 16333, 0, SYM_DOT));
    dir_rows.push_back(frame_row(ROW_FRAME, 3, 1, 2, 3, SYM_DOT));
    dir_rows.push_back(reg_row(REG_START_COUNT, 63));
    dir_rows.push_back(reg_row(REG_END_COUNT, 0));
    dir_rows.push_back(frame_row(ROW_FRAME, 1, 16333, 0, 0, SYM_DOT));

    // Hold reset, then release it on a falling clock edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Walk the directed table; registers change only with the block idle
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REG) begin
        drain();
        write_reg(dir_rows[i].regsel, int'(dir_rows[i].data));
      end else begin
        send_frame(dir_rows[i].frame, dir_rows[i].kind != ROW_FRAME,
                   dir_rows[i].kind == ROW_FRAME_SYM, dir_rows[i].sym);
      end
    end

    for (p = 0; p < N_PHASES; p++) run_phase(p);

    // Saturate the tone counter, close the message with a long gap, then open a new one
    drain();
    set_idling(3);
    write_reg(REG_TIME_UNIT, 1);
    write_reg(REG_START_COUNT, 1);
    write_reg(REG_END_COUNT, 1);
    send_run(1'b1, SAT_RUN, 0);
    send_run(1'b0, 2 * EOT_UNITS, 0);
    send_run(1'b1, 2, 0);
    send_run(1'b0, 2, 0);

    drain();
    if (err_cnt == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

/* files.f */
+incdir+src
src/msr_pkg.sv
src/msr_cfg_regs.sv
src/msr_tone_detect.sv
src/msr_symbol_fsm.sv
src/morse_tone_symbol_recogniser.sv
sim/morse_tone_symbol_recogniser_tb.sv
